@@ hdl/dcrt_pkg.sv @@
`default_nettype none

package dcrt_pkg;

   localparam int GROUP_SLOTS = 64;
   localparam int GROUP_COUNT = 256;

   localparam int CODE_W     = 32;
   localparam int MODE_W     = 2;
   localparam int LEN_W      = 7;
   localparam int SLOT_W     = $clog2(GROUP_SLOTS);
   localparam int GRP_W      = $clog2(GROUP_COUNT);
   localparam int ADDR_W     = GRP_W + SLOT_W;
   localparam int CODE_DEPTH = GROUP_SLOTS * GROUP_COUNT;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [SLOT_W-1:0] SLOT_MAX   = SLOT_W'(GROUP_SLOTS - 1);
   localparam logic [GRP_W-1:0]  GRP_MAX    = GRP_W'(GROUP_COUNT - 1);
   localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(GROUP_SLOTS);
   localparam logic [LEN_W-1:0]  RING_RESET = 7'd64;

   localparam logic [MODE_W-1:0] MODE_CHECK    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COMMIT   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ROLLBACK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RING_LENGTH = 1'd1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_WIPE,
      OP_SCAN,
      OP_INSERT,
      OP_CMT_RD,
      OP_CMT_WR,
      OP_RB_RD,
      OP_RB_CLR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load;
      logic      grp_clr;
      logic      grp_inc;
      logic      slot_clr;
      logic      slot_inc;
   } dp_cmd_type;

   typedef struct packed {
      logic active;
      logic match;
      logic slot_end;
      logic slot_last;
      logic grp_last;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ hdl/duplicate_code_ring_table_unit.sv @@
// Channel   Handshake                     Payload
// request   start & !busy                 req_mode, req_msg_code, req_node_code, req_area_crc
// result    rsp_valid (one-cycle strobe)  rsp_is_duplicate, rsp_inserted
// config    csr_valid & csr_ready         csr_index, csr_wdata
//
// Check: one read of the code memory per slot over min(ring_length, 64) slots before an
// insert; a match ends the scan early, and with detection off no scan is made.
// Commit: pointer copy, group by group, a read state then a write state per group.
// Rollback: one slot of the code memory per cycle, after a read of each group's pointers.
// Reset: busy stays high through a clearing pass; config writes are taken meanwhile.
// Results cannot be stalled; the next item may be accepted while one is shown.
`default_nettype none

module duplicate_code_ring_table_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [dcrt_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [dcrt_pkg::CODE_W-1:0]     req_msg_code,
   input  wire logic [dcrt_pkg::CODE_W-1:0]     req_node_code,
   input  wire logic [dcrt_pkg::CODE_W-1:0]     req_area_crc,
   output logic                                 rsp_valid,
   output logic                                 rsp_is_duplicate,
   output logic                                 rsp_inserted,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [dcrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dcrt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dcrt_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   dcrt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .rsp_valid        (rsp_valid),
      .rsp_is_duplicate (rsp_is_duplicate),
      .rsp_inserted     (rsp_inserted),
      .cmd              (cmd),
      .stat             (stat)
   );

   dcrt_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_msg_code  (req_msg_code),
      .req_node_code (req_node_code),
      .req_area_crc  (req_area_crc),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

endmodule

`default_nettype wire

@@ hdl/dcrt_dpath.sv @@
`default_nettype none

module dcrt_dpath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire dcrt_pkg::dp_cmd_type            cmd,
   output dcrt_pkg::dp_stat_type                stat,
   input  wire logic [dcrt_pkg::CODE_W-1:0]     req_msg_code,
   input  wire logic [dcrt_pkg::CODE_W-1:0]     req_node_code,
   input  wire logic [dcrt_pkg::CODE_W-1:0]     req_area_crc,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [dcrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dcrt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dcrt_pkg::*;

   logic [CODE_W-1:0] code_mem [CODE_DEPTH];
   logic [SLOT_W-1:0] wp_mem   [GROUP_COUNT];
   logic [SLOT_W-1:0] cp_mem   [GROUP_COUNT];

   logic              enable_ff;
   logic [LEN_W-1:0]  ring_ff;
   logic [GRP_W-1:0]  grp_ff, grp_in;
   logic [LEN_W-1:0]  slot_ff, slot_in;
   logic [CODE_W-1:0] key_ff;
   logic              cmp_vld_ff;
   logic [CODE_W-1:0] code_rd_ff;
   logic [SLOT_W-1:0] wp_rd_ff;
   logic [SLOT_W-1:0] cp_rd_ff;

   logic [LEN_W-1:0]  len;
   logic [SLOT_W-1:0] slot;
   logic [SLOT_W-1:0] ins_slot;
   logic [LEN_W-1:0]  ins_next;
   logic [SLOT_W-1:0] wp_next;
   logic              rb_hit;

   logic              code_we, code_re;
   logic [ADDR_W-1:0] code_waddr;
   logic [CODE_W-1:0] code_wdata;
   logic              wp_we, wp_re, cp_we, cp_re;
   logic [SLOT_W-1:0] wp_wdata, cp_wdata;

   assign csr_ready = 1'b1;
   assign len  = (ring_ff > LEN_LIMIT) ? LEN_LIMIT : ring_ff;
   assign slot = slot_ff[SLOT_W-1:0];

   assign ins_slot = (LEN_W'(wp_rd_ff) >= len) ? '0 : wp_rd_ff;
   assign ins_next = LEN_W'(ins_slot) + LEN_W'(1);
   assign wp_next  = (ins_next >= len) ? '0 : ins_next[SLOT_W-1:0];

   always_comb begin
      rb_hit = 1'b0;
      if (cp_rd_ff < wp_rd_ff) begin
         rb_hit = (slot >= cp_rd_ff) && (slot < wp_rd_ff);
      end else if (cp_rd_ff > wp_rd_ff) begin
         rb_hit = (slot < wp_rd_ff) || ((slot >= cp_rd_ff) && (LEN_W'(slot) < len));
      end
   end

   always_comb begin
      code_we    = 1'b0;
      code_re    = 1'b0;
      code_waddr = {grp_ff, slot};
      code_wdata = '0;
      wp_we      = 1'b0;
      wp_re      = 1'b0;
      wp_wdata   = '0;
      cp_we      = 1'b0;
      cp_re      = 1'b0;
      cp_wdata   = '0;
      unique case (cmd.op)
         OP_WIPE: begin
            code_we = 1'b1;
            wp_we   = (slot == '0);
            cp_we   = (slot == '0);
         end
         OP_SCAN: begin
            code_re = (slot_ff < len);
            wp_re   = 1'b1;
         end
         OP_INSERT: begin
            code_we    = 1'b1;
            code_waddr = {grp_ff, ins_slot};
            code_wdata = key_ff;
            wp_we      = 1'b1;
            wp_wdata   = wp_next;
         end
         OP_CMT_RD: begin
            wp_re = 1'b1;
         end
         OP_CMT_WR: begin
            cp_we    = 1'b1;
            cp_wdata = wp_rd_ff;
         end
         OP_RB_RD: begin
            wp_re = 1'b1;
            cp_re = 1'b1;
         end
         OP_RB_CLR: begin
            code_we  = rb_hit;
            wp_we    = (slot == '0);
            wp_wdata = cp_rd_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (code_we) begin
         code_mem[code_waddr] <= code_wdata;
      end
      if (code_re) begin
         code_rd_ff <= code_mem[{grp_ff, slot}];
      end
      if (wp_we) begin
         wp_mem[grp_ff] <= wp_wdata;
      end
      if (wp_re) begin
         wp_rd_ff <= wp_mem[grp_ff];
      end
      if (cp_we) begin
         cp_mem[grp_ff] <= cp_wdata;
      end
      if (cp_re) begin
         cp_rd_ff <= cp_mem[grp_ff];
      end
   end

   always_comb begin
      grp_in = grp_ff;
      if (cmd.grp_clr) begin
         grp_in = '0;
      end else if (cmd.load) begin
         grp_in = req_msg_code[GRP_W-1:0];
      end else if (cmd.grp_inc) begin
         grp_in = grp_ff + GRP_W'(1);
      end
      slot_in = slot_ff;
      if (cmd.slot_clr) begin
         slot_in = '0;
      end else if (cmd.slot_inc) begin
         slot_in = slot_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b1;
         ring_ff    <= RING_RESET;
         grp_ff     <= '0;
         slot_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_ENABLE:      enable_ff <= csr_wdata[0];
               REG_RING_LENGTH: ring_ff   <= csr_wdata[LEN_W-1:0];
               default: begin
               end
            endcase
         end
         grp_ff     <= grp_in;
         slot_ff    <= slot_in;
         cmp_vld_ff <= code_re;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_msg_code ^ req_node_code ^ req_area_crc;
      end
   end

   always_comb begin
      stat.active    = enable_ff && (len != '0);
      stat.match     = cmp_vld_ff && (code_rd_ff == key_ff);
      stat.slot_end  = (slot_ff >= len);
      stat.slot_last = (slot == SLOT_MAX);
      stat.grp_last  = (grp_ff == GRP_MAX);
   end

endmodule

`default_nettype wire

@@ hdl/dcrt_ctrl.sv @@
`default_nettype none

module dcrt_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [dcrt_pkg::MODE_W-1:0] req_mode,
   output logic                             rsp_valid,
   output logic                             rsp_is_duplicate,
   output logic                             rsp_inserted,
   output dcrt_pkg::dp_cmd_type             cmd,
   input  wire dcrt_pkg::dp_stat_type       stat
);
   import dcrt_pkg::*;

   typedef enum logic [3:0] {
      S_WIPE,
      S_IDLE,
      S_SCAN,
      S_INSERT,
      S_CMT_RD,
      S_CMT_WR,
      S_RB_RD,
      S_RB_CLR
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      dup_ff, dup_in;
   logic      ins_ff, ins_in;

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_is_duplicate = dup_ff;
   assign rsp_inserted     = ins_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      dup_in   = 1'b0;
      ins_in   = 1'b0;
      cmd      = '0;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_WIPE: begin
            cmd.op = OP_WIPE;
            if (stat.slot_last) begin
               cmd.slot_clr = 1'b1;
               cmd.grp_inc  = 1'b1;
               if (stat.grp_last) begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.slot_inc = 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_mode)
                  MODE_CHECK: begin
                     if (stat.active) begin
                        cmd.slot_clr = 1'b1;
                        state_in     = S_SCAN;
                     end else begin
                        valid_in = 1'b1;
                     end
                  end
                  MODE_COMMIT: begin
                     cmd.grp_clr = 1'b1;
                     state_in    = S_CMT_RD;
                  end
                  MODE_ROLLBACK: begin
                     if (stat.active) begin
                        cmd.grp_clr  = 1'b1;
                        cmd.slot_clr = 1'b1;
                        state_in     = S_RB_RD;
                     end else begin
                        valid_in = 1'b1;
                     end
                  end
                  default: begin
                     valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.match) begin
               valid_in = 1'b1;
               dup_in   = 1'b1;
               state_in = S_IDLE;
            end else if (stat.slot_end) begin
               state_in = S_INSERT;
            end else begin
               cmd.slot_inc = 1'b1;
            end
         end
         S_INSERT: begin
            cmd.op   = OP_INSERT;
            valid_in = 1'b1;
            ins_in   = 1'b1;
            state_in = S_IDLE;
         end
         S_CMT_RD: begin
            cmd.op   = OP_CMT_RD;
            state_in = S_CMT_WR;
         end
         S_CMT_WR: begin
            cmd.op = OP_CMT_WR;
            if (stat.grp_last) begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.grp_inc = 1'b1;
               state_in    = S_CMT_RD;
            end
         end
         S_RB_RD: begin
            cmd.op   = OP_RB_RD;
            state_in = S_RB_CLR;
         end
         S_RB_CLR: begin
            cmd.op = OP_RB_CLR;
            if (stat.slot_last) begin
               cmd.slot_clr = 1'b1;
               if (stat.grp_last) begin
                  valid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.grp_inc = 1'b1;
                  state_in    = S_RB_RD;
               end
            end else begin
               cmd.slot_inc = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
         valid_ff <= 1'b0;
         dup_ff   <= 1'b0;
         ins_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         dup_ff   <= dup_in;
         ins_ff   <= ins_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_is_duplicate && rsp_inserted))
      else $error("duplicate and inserted reported together");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_is_duplicate || rsp_inserted) |-> rsp_valid)
      else $error("result flag without strobe");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_COMMIT) |=> (busy && !rsp_valid))
      else $error("commit did not start its sweep");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("store clearing pass skipped after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inserted) |-> ($past(state_ff) == S_INSERT))
      else $error("insert reported without write");

endmodule

`default_nettype wire
